// ----- hw/rtl/complex_arithmetic_unit_defines.svh -----
// Assertion macros used by the checker file of the complex arithmetic unit.
// Depends on nothing; included by the checker.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define CAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/cau_pkg.sv -----
// Package for the complex arithmetic unit: opcodes and widths.
// Depends on nothing.
`timescale 1ns / 1ps
package cau_pkg;
    localparam int OPERAND_WIDTH = 16;
    localparam int FRAC_BITS     = 16;
    localparam int RES_WIDTH     = 48;
    localparam int OPCODE_WIDTH  = 3;

    typedef enum logic [OPCODE_WIDTH-1:0] {
        OP_PASS0 = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_CONJ  = 3'd5,
        OP_PASS6 = 3'd6,
        OP_PASS7 = 3'd7
    } t_opcode;
endpackage

// ----- hw/rtl/cau_if.sv -----
// Valid/ready channel interfaces for the complex arithmetic unit.
// Depends on cau_pkg.
`timescale 1ns / 1ps
interface cau_in_if #(
    parameter int OPERAND_WIDTH = cau_pkg::OPERAND_WIDTH
);
    logic                              valid;
    logic                              ready;
    logic [cau_pkg::OPCODE_WIDTH-1:0]  opcode;
    logic signed [OPERAND_WIDTH-1:0]   a_real;
    logic signed [OPERAND_WIDTH-1:0]   a_imag;
    logic signed [OPERAND_WIDTH-1:0]   b_real;
    logic signed [OPERAND_WIDTH-1:0]   b_imag;

    modport source (output valid, opcode, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, opcode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cau_pkg::RES_WIDTH-1:0]  res_real;
    logic signed [cau_pkg::RES_WIDTH-1:0]  res_imag;
    logic                                  div_by_zero;

    modport source (output valid, res_real, res_imag, div_by_zero, input ready);
    modport sink   (input valid, res_real, res_imag, div_by_zero, output ready);
endinterface

// ----- hw/rtl/complex_arithmetic_unit.sv -----
// Complex arithmetic unit top level: a multiply stage, a combine stage, a
// pipelined divider, and an output register. Depends on cau_pkg, cau_if
// and cau_divider.
//
// Usage: operand beats arrive on s_in (opcode, a_real, a_imag, b_real, b_imag)
// and one result beat per operand beat leaves on m_out (res_real, res_imag,
// div_by_zero), in order. Results are signed fixed point with FRAC_BITS
// fraction bits, saturated to 48 bits.
// Throughput: one beat per cycle while m_out is not stalled. Every opcode
// travels through the bit-per-stage divider, which sets the pipeline depth.
// Reset clears every valid bit; payload registers are not reset.
// A stall on m_out freezes the whole pipeline; s_in.ready is high while the
// output register is empty or m_out.ready is high, and nothing is lost or
// repeated.
`timescale 1ns / 1ps
module complex_arithmetic_unit #(
    parameter int OPERAND_WIDTH = cau_pkg::OPERAND_WIDTH,
    parameter int FRAC_BITS     = cau_pkg::FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cau_in_if.sink     s_in,
    cau_out_if.source  m_out
);
    localparam int OW   = OPERAND_WIDTH;
    localparam int PW   = 2 * OW + 1;     // products and their sums
    localparam int RESW = cau_pkg::RES_WIDTH;
    localparam int TW   = 2 * RESW + 2;   // tag: bypass real, imag, flag, use-bypass

    typedef struct packed {
        logic [RESW-1:0] re;
        logic [RESW-1:0] im;
        logic            dz;
        logic            bypass;
    } t_tag;

    logic w_en;
    logic r_out_vld;
    assign w_en = !r_out_vld || m_out.ready;
    assign s_in.ready = w_en;

    // Stage 1: four cross products and the two squares of b.
    logic                 r1_vld;
    cau_pkg::t_opcode     r1_op;
    logic signed [OW-1:0] r1_ar, r1_ai, r1_br, r1_bi;
    logic signed [2*OW-1:0] r1_rr, r1_ii, r1_ri, r1_ir;
    logic signed [2*OW-1:0] r1_bsq_r, r1_bsq_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= s_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_op    <= cau_pkg::t_opcode'(s_in.opcode);
            r1_ar    <= s_in.a_real;
            r1_ai    <= s_in.a_imag;
            r1_br    <= s_in.b_real;
            r1_bi    <= s_in.b_imag;
            r1_rr    <= s_in.a_real * s_in.b_real;
            r1_ii    <= s_in.a_imag * s_in.b_imag;
            r1_ri    <= s_in.a_real * s_in.b_imag;
            r1_ir    <= s_in.a_imag * s_in.b_real;
            r1_bsq_r <= s_in.b_real * s_in.b_real;
            r1_bsq_i <= s_in.b_imag * s_in.b_imag;
        end
    end

    // Stage 2: sums, scaling of integer results, divider operands.
    function automatic logic [RESW-1:0] scale_sat(input logic signed [PW-1:0] v);
        logic signed [PW+FRAC_BITS-1:0] v_s;
        logic signed [PW+FRAC_BITS-1:0] v_hi;
        logic signed [PW+FRAC_BITS-1:0] v_lo;
        v_s  = (PW+FRAC_BITS)'(v) <<< FRAC_BITS;
        v_hi = (PW+FRAC_BITS)'((65'sd1 <<< (RESW - 1)) - 65'sd1);
        v_lo = -((PW+FRAC_BITS)'(65'sd1 <<< (RESW - 1)));
        if (PW + FRAC_BITS <= RESW) begin
            scale_sat = RESW'(v_s);
        end else if (v_s > v_hi) begin
            scale_sat = RESW'(v_hi);
        end else if (v_s < v_lo) begin
            scale_sat = RESW'(v_lo);
        end else begin
            scale_sat = RESW'(v_s);
        end
    endfunction

    logic                 r2_vld;
    t_tag                 r2_tag;
    logic [PW-1:0]        r2_num_re, r2_num_im, r2_den;
    logic                 r2_neg_re, r2_neg_im;

    logic signed [PW-1:0] w_sr, w_si, w_nr, w_ni, w_den;
    logic                 w_bz;
    always_comb begin
        w_bz  = (r1_br == '0) && (r1_bi == '0);
        w_nr  = PW'(r1_rr) + PW'(r1_ii);
        w_ni  = PW'(r1_ir) - PW'(r1_ri);
        w_den = PW'(r1_bsq_r) + PW'(r1_bsq_i);
        unique case (r1_op)
            cau_pkg::OP_ADD: begin
                w_sr = PW'(r1_ar) + PW'(r1_br);
                w_si = PW'(r1_ai) + PW'(r1_bi);
            end
            cau_pkg::OP_SUB: begin
                w_sr = PW'(r1_ar) - PW'(r1_br);
                w_si = PW'(r1_ai) - PW'(r1_bi);
            end
            cau_pkg::OP_MUL: begin
                w_sr = PW'(r1_rr) - PW'(r1_ii);
                w_si = PW'(r1_ri) + PW'(r1_ir);
            end
            cau_pkg::OP_CONJ: begin
                w_sr = PW'(r1_ar);
                w_si = -PW'(r1_ai);
            end
            default: begin
                w_sr = PW'(r1_ar);
                w_si = PW'(r1_ai);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_tag.re     <= scale_sat(w_sr);
            r2_tag.im     <= scale_sat(w_si);
            r2_tag.dz     <= (r1_op == cau_pkg::OP_DIV) && w_bz;
            r2_tag.bypass <= (r1_op != cau_pkg::OP_DIV) || w_bz;
            r2_num_re     <= w_nr[PW-1] ? PW'(-w_nr) : PW'(w_nr);
            r2_num_im     <= w_ni[PW-1] ? PW'(-w_ni) : PW'(w_ni);
            r2_neg_re     <= w_nr[PW-1];
            r2_neg_im     <= w_ni[PW-1];
            r2_den        <= w_bz ? PW'(1) : PW'(w_den);
        end
    end

    // Divider lanes for the two parts.
    logic                 w_dv_vld, w_dv_vld_im;
    logic [RESW-1:0]      w_q_re, w_q_im;
    logic [TW-1:0]        w_dv_tag, w_dv_tag_im;
    t_tag                 w_tag;

    cau_divider #(
        .NUM_WIDTH (PW), .DEN_WIDTH (PW), .FRAC_BITS (FRAC_BITS), .TAG_WIDTH (TW)
    ) u_div_re (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (r2_vld), .i_num (r2_num_re), .i_den (r2_den), .i_neg (r2_neg_re),
        .i_tag (r2_tag), .o_valid (w_dv_vld), .o_res (w_q_re), .o_tag (w_dv_tag)
    );

    cau_divider #(
        .NUM_WIDTH (PW), .DEN_WIDTH (PW), .FRAC_BITS (FRAC_BITS), .TAG_WIDTH (TW)
    ) u_div_im (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (r2_vld), .i_num (r2_num_im), .i_den (r2_den), .i_neg (r2_neg_im),
        .i_tag (r2_tag), .o_valid (w_dv_vld_im), .o_res (w_q_im), .o_tag (w_dv_tag_im)
    );

    assign w_tag = t_tag'(w_dv_tag);

    // Output register.
    logic [RESW-1:0] r_out_re, r_out_im;
    logic            r_out_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld && w_dv_vld_im && (w_dv_tag_im == w_dv_tag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_re <= w_tag.bypass ? w_tag.re : w_q_re;
            r_out_im <= w_tag.bypass ? w_tag.im : w_q_im;
            r_out_dz <= w_tag.dz;
        end
    end

    assign m_out.valid       = r_out_vld;
    assign m_out.res_real    = r_out_re;
    assign m_out.res_imag    = r_out_im;
    assign m_out.div_by_zero = r_out_dz;
endmodule

// ----- hw/rtl/cau_divider.sv -----
// Pipelined restoring divider: one quotient bit per stage, one copy per result part.
// Depends on cau_pkg. Quotient saturates to the result field.
`timescale 1ns / 1ps
module cau_divider #(
    parameter int NUM_WIDTH = 2 * cau_pkg::OPERAND_WIDTH + 1,
    parameter int DEN_WIDTH = 2 * cau_pkg::OPERAND_WIDTH + 1,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS,
    parameter int TAG_WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [NUM_WIDTH-1:0]  i_num,
    input  logic [DEN_WIDTH-1:0]  i_den,
    input  logic                  i_neg,
    input  logic [TAG_WIDTH-1:0]  i_tag,
    output logic                  o_valid,
    output logic [cau_pkg::RES_WIDTH-1:0] o_res,
    output logic [TAG_WIDTH-1:0]  o_tag
);
    // Quotient bits: integer part plus fraction bits.
    localparam int QW     = NUM_WIDTH + FRAC_BITS;
    localparam int STAGES = QW;
    localparam int RW     = DEN_WIDTH + 1;
    localparam int RESW   = cau_pkg::RES_WIDTH;

    logic [RW-1:0]        r_rem   [STAGES+1];
    logic [QW-1:0]        r_quo   [STAGES+1];
    logic [QW-1:0]        r_dvd   [STAGES+1];
    logic [DEN_WIDTH-1:0] r_den   [STAGES+1];
    logic                 r_neg   [STAGES+1];
    logic [TAG_WIDTH-1:0] r_tag   [STAGES+1];
    logic                 r_vld   [STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 0; s < STAGES; s++) begin
                r_vld[s+1] <= r_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_quo[0] <= '0;
            r_dvd[0] <= {i_num, {FRAC_BITS{1'b0}}};
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            r_tag[0] <= i_tag;
            for (int s = 0; s < STAGES; s++) begin
                logic [RW-1:0] v_try;
                v_try = {r_rem[s][RW-2:0], r_dvd[s][QW-1]};
                if (v_try >= {1'b0, r_den[s]}) begin
                    r_rem[s+1] <= v_try - {1'b0, r_den[s]};
                    r_quo[s+1] <= {r_quo[s][QW-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= v_try;
                    r_quo[s+1] <= {r_quo[s][QW-2:0], 1'b0};
                end
                r_dvd[s+1] <= {r_dvd[s][QW-2:0], 1'b0};
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                r_tag[s+1] <= r_tag[s];
            end
        end
    end

    // Saturate the magnitude and apply the sign.
    localparam logic [QW:0] POS_LIM = (QW+1)'((65'd1 << (RESW - 1)) - 65'd1);
    localparam logic [QW:0] NEG_LIM = (QW+1)'(65'd1 << (RESW - 1));
    logic [QW:0]        w_q;
    logic [QW:0]        w_lim;
    logic [RESW-1:0]    w_mag;
    always_comb begin
        w_q   = {1'b0, r_quo[STAGES]};
        w_lim = r_neg[STAGES] ? NEG_LIM : POS_LIM;
        w_mag = (w_q > w_lim) ? RESW'(w_lim) : RESW'(w_q);
        o_res = r_neg[STAGES] ? RESW'(-w_mag) : w_mag;
    end
    assign o_valid = r_vld[STAGES];
    assign o_tag   = r_tag[STAGES];
endmodule

// ----- hw/rtl/cau_checker.sv -----
// Port-level checker for the complex arithmetic unit, bound to the top level.
// Depends on complex_arithmetic_unit_defines.svh and cau_pkg.
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_defines.svh"
module cau_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [cau_pkg::RES_WIDTH-1:0] out_re,
    input logic                         out_dz
);
    `CAU_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    `CAU_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, out_valid && !out_ready, $stable(out_re) && $stable(out_dz))
    `CAU_ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !out_valid || out_ready, in_ready)
    `CAU_ASSERT_IMPL(a_stall_blocks, i_clk, i_rst_n, out_valid && !out_ready, !in_ready)
endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (s_in.ready),
    .out_valid (m_out.valid),
    .out_ready (m_out.ready),
    .out_re    (m_out.res_real),
    .out_dz    (m_out.div_by_zero)
);
